// File: hdl/rsmp_pkg.sv
// Shared types, widths and codes for the linear-interpolation resampler.
`default_nettype none

package rsmp_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int SAMPLE_FIELDS = 4;
    localparam int PHASE_W       = 37;
    localparam int CHAN_W        = 3;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 37;
    localparam int RESULT_CAP    = 64;
    localparam int COUNT_W       = 7;

    localparam logic [PHASE_W-1:0] ONE_PHASE = 37'h01_0000_0000;
    localparam logic [PHASE_W-1:0] STEP_MIN  = 37'd67108864;
    localparam logic [PHASE_W-1:0] STEP_MAX  = 37'd68719476736;
    localparam logic [PHASE_W-1:0] STEP_RST  = 37'd4294967296;
    localparam logic [CHAN_W-1:0]  CHANS_RST = 3'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CHANNELS = 2'd1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [PHASE_W-1:0]         phase_t;

    // Operands handed to the shared interpolation unit.
    typedef struct packed {
        logic    load;
        sample_t a;
        sample_t b;
    } lerp_req_t;

endpackage

`default_nettype wire

// File: hdl/phase_accumulator_linear_resampler.sv
// Top level of the linear-interpolation sample rate converter.
`default_nettype none

// Each accepted input word carries one frame of up to four channels. A start
// word, or the first word after reset, loads the frame and clears the phase
// without output. Every other word yields the output frames, up to 64, that
// fall between the previous frame and this one (none if the phase is already
// past it), each built channel by channel in a single shared multiplier
// through the MUL and ACC states and then pushed in PUSH, which waits while
// the output side stalls. The block takes no input word while it is producing
// frames; a finished frame waits in the output register while the next one is
// built.
module phase_accumulator_linear_resampler #(
    parameter int MAX_CHANNELS  = 4,
    parameter int FRACTION_BITS = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [rsmp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rsmp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               start_req,
    input  wire rsmp_pkg::sample_t                  sample_0,
    input  wire rsmp_pkg::sample_t                  sample_1,
    input  wire rsmp_pkg::sample_t                  sample_2,
    input  wire rsmp_pkg::sample_t                  sample_3,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output rsmp_pkg::sample_t                       out_0,
    output rsmp_pkg::sample_t                       out_1,
    output rsmp_pkg::sample_t                       out_2,
    output rsmp_pkg::sample_t                       out_3,
    output logic                                    last
);
    import rsmp_pkg::*;

    localparam int LANES = (MAX_CHANNELS < SAMPLE_FIELDS) ? MAX_CHANNELS : SAMPLE_FIELDS;
    localparam logic [CHAN_W-1:0] LANES_C  = CHAN_W'(LANES);
    localparam logic [1:0]        LANES_M1 = 2'(LANES - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_ACC  = 2'd2;
    localparam logic [1:0] ST_PUSH = 2'd3;

    logic [1:0]         state_reg;
    logic [1:0]         ch_reg;
    logic [COUNT_W-1:0] count_reg;
    phase_t             phase_reg;
    logic               have_prev_reg;
    phase_t             step_reg;
    logic [CHAN_W-1:0]  chans_reg;
    logic               out_valid_reg;

    sample_t prev_reg  [SAMPLE_FIELDS];
    sample_t frame_reg [SAMPLE_FIELDS];
    sample_t res_reg   [SAMPLE_FIELDS];
    sample_t out_reg   [SAMPLE_FIELDS];
    logic    last_reg;

    sample_t   in_frame [SAMPLE_FIELDS];
    phase_t    step_eff;
    logic [1:0] chans_m1;
    logic      in_accept;
    logic      out_take;
    logic      out_free;
    phase_t    phase_sum;
    logic      sum_ge_one;
    logic      last_now;
    phase_t    phase_after;
    lerp_req_t lerp_req;
    sample_t   lerp_y;

    assign in_frame[0] = sample_0;
    assign in_frame[1] = sample_1;
    assign in_frame[2] = sample_2;
    assign in_frame[3] = sample_3;

    always_comb
    begin
        priority if (step_reg < STEP_MIN)
            step_eff = STEP_MIN;
        else if (step_reg > STEP_MAX)
            step_eff = STEP_MAX;
        else
            step_eff = step_reg;
    end

    always_comb
    begin
        priority if (chans_reg == '0)
            chans_m1 = 2'd0;
        else if (chans_reg > LANES_C)
            chans_m1 = LANES_M1;
        else
            chans_m1 = 2'(chans_reg - 3'd1);
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_free  = !out_valid_reg || out_take;

    assign phase_sum   = phase_reg + step_eff;
    assign sum_ge_one  = |phase_sum[PHASE_W-1:32];
    assign last_now    = sum_ge_one || (count_reg == COUNT_W'(RESULT_CAP - 1));
    assign phase_after = sum_ge_one ? (phase_sum - ONE_PHASE) : '0;

    assign lerp_req.load = (state_reg == ST_MUL);
    assign lerp_req.a    = prev_reg[ch_reg];
    assign lerp_req.b    = frame_reg[ch_reg];

    rsmp_lerp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_lerp (
        .clk  (clk),
        .req  (lerp_req),
        .frac (phase_reg[31 -: FRACTION_BITS]),
        .y    (lerp_y)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= STEP_RST;
            chans_reg <= CHANS_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PHASE_STEP:      step_reg  <= cfg_data;
                REG_ACTIVE_CHANNELS: chans_reg <= cfg_data[CHAN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer and phase accumulator.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= '0;
            count_reg     <= '0;
            phase_reg     <= '0;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_PUSH) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        priority if (start_req || !have_prev_reg)
                        begin
                            phase_reg     <= '0;
                            have_prev_reg <= 1'b1;
                        end
                        else if (|phase_reg[PHASE_W-1:32])
                            // Already past the new frame: no output this word.
                            phase_reg <= phase_reg - ONE_PHASE;
                        else
                        begin
                            state_reg <= ST_MUL;
                            ch_reg    <= '0;
                            count_reg <= '0;
                        end
                    end
                end
                ST_MUL:
                    state_reg <= ST_ACC;
                ST_ACC:
                begin
                    if (ch_reg == chans_m1)
                        state_reg <= ST_PUSH;
                    else
                    begin
                        ch_reg    <= ch_reg + 2'd1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_PUSH:
                begin
                    if (out_free)
                    begin
                        ch_reg <= '0;
                        if (last_now)
                        begin
                            phase_reg <= phase_after;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            phase_reg <= phase_sum;
                            count_reg <= count_reg + COUNT_W'(1);
                            state_reg <= ST_MUL;
                        end
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // Frame storage and output words.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            if (start_req || !have_prev_reg || (|phase_reg[PHASE_W-1:32]))
                prev_reg <= in_frame;
            else
                frame_reg <= in_frame;
        end

        if (state_reg == ST_ACC)
            res_reg[ch_reg] <= lerp_y;

        if ((state_reg == ST_PUSH) && out_free)
        begin
            for (int c = 0; c < SAMPLE_FIELDS; c++)
                out_reg[c] <= (2'(c) <= chans_m1) ? res_reg[c] : '0;
            last_reg <= last_now;
            if (last_now)
                prev_reg <= frame_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_0     = out_reg[0];
    assign out_1     = out_reg[1];
    assign out_2     = out_reg[2];
    assign out_3     = out_reg[3];
    assign last      = last_reg;

endmodule

`default_nettype wire

// File: hdl/rsmp_lerp.sv
// Shared interpolation unit: one registered multiply, then add and truncate toward zero.
`default_nettype none

module rsmp_lerp #(
    parameter int FRACTION_BITS = 32
) (
    input  wire logic                     clk,
    input  wire rsmp_pkg::lerp_req_t      req,
    input  wire logic [FRACTION_BITS-1:0] frac,
    output rsmp_pkg::sample_t             y
);
    import rsmp_pkg::*;

    localparam int PROD_W = SAMPLE_W + FRACTION_BITS + 2;
    localparam int NUM_W  = PROD_W + 1;

    logic signed [SAMPLE_W:0]      diff;
    logic signed [FRACTION_BITS:0] frac_s;
    logic signed [PROD_W-1:0]      prod_reg;
    sample_t                       a_reg;
    logic signed [NUM_W-1:0]       a_ext;
    logic signed [NUM_W-1:0]       num;
    logic        [NUM_W-1:0]       bias;
    logic        [NUM_W-1:0]       rounded;

    assign diff   = $signed({req.b[SAMPLE_W-1], req.b}) - $signed({req.a[SAMPLE_W-1], req.a});
    assign frac_s = $signed({1'b0, frac});

    always_ff @(posedge clk)
    begin
        if (req.load)
        begin
            prod_reg <= diff * frac_s;
            a_reg    <= req.a;
        end
    end

    assign a_ext = {{(NUM_W - SAMPLE_W - FRACTION_BITS){a_reg[SAMPLE_W-1]}}, a_reg,
                    {FRACTION_BITS{1'b0}}};
    assign num   = a_ext + $signed({prod_reg[PROD_W-1], prod_reg});

    // Adding all ones below the binary point to a negative value turns the
    // arithmetic shift into a truncation toward zero.
    assign bias    = {{(NUM_W - FRACTION_BITS){1'b0}}, {FRACTION_BITS{num[NUM_W-1]}}};
    assign rounded = num + bias;
    assign y       = rounded[FRACTION_BITS+SAMPLE_W-1:FRACTION_BITS];

endmodule

`default_nettype wire

// File: hdl/rsmp_checker.sv
// Port-level checks on the resampler, bound to its top level.
`default_nettype none

module rsmp_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_stall,
    input wire logic              start_req,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire rsmp_pkg::sample_t out_0,
    input wire rsmp_pkg::sample_t out_1,
    input wire rsmp_pkg::sample_t out_2,
    input wire rsmp_pkg::sample_t out_3,
    input wire logic              last
);

    // A stalled output word stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_0) && $stable(out_1)
            && $stable(out_2) && $stable(out_3) && $stable(last))
        else $error("output word changed while stalled");

    // A start word only loads the frame, so it never raises an output.
    a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && start_req && !out_valid |=> !out_valid)
        else $error("start word produced an output");

    // After a word that is not the last, either the next word is already
    // shown or the block is still busy building it.
    a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid || in_stall)
        else $error("block went idle before the last output word");

    // Nothing is accepted while the block is building output words.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> in_stall)
        else $error("input accepted while output words were pending");

endmodule

bind phase_accumulator_linear_resampler rsmp_checker u_rsmp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .start_req (start_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_0     (out_0),
    .out_1     (out_1),
    .out_2     (out_2),
    .out_3     (out_3),
    .last      (last)
);

`default_nettype wire

// File: verif/tb_phase_accumulator_linear_resampler.sv
// Self-checking testbench for the linear-interpolation sample rate converter.
`timescale 1ns / 1ps

module tb_phase_accumulator_linear_resampler;

    import rsmp_pkg::*;

    localparam int      HALF_PERIOD   = 4;
    localparam int      SETTLE_CYCLES = 16;
    localparam int      HOLD_CYCLES   = 300;
    localparam int      RANDOM_WORDS  = 353;
    localparam int      QUIET_FROM    = 300;
    localparam int      PRINT_CAP     = 30;
    localparam longint  FRAC_SCALE    = 64'sd4294967296;
    localparam sample_t S_MAX         = 16'sh7FFF;
    localparam sample_t S_MIN         = 16'sh8000;

    // Index with no register behind it; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;

    typedef struct packed {
        sample_t ch0;
        sample_t ch1;
        sample_t ch2;
        sample_t ch3;
        logic    last;
    } out_frame_t;

    class frame_scoreboard;
        phase_t             step_reg;
        logic [CHAN_W-1:0]  chans_reg;
        sample_t            prev [SAMPLE_FIELDS];
        phase_t             phase;
        bit                 primed;
        out_frame_t         pending_frames [$];
        int                 errors;

        function new();
            step_reg  = STEP_RST;
            chans_reg = CHANS_RST;
            phase     = '0;
            primed    = 1'b0;
            errors    = 0;
            foreach (prev[c])
                prev[c] = '0;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= PRINT_CAP)
                $display("MISMATCH at %0t ns: %s", $time, msg);
        endtask

        function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_PHASE_STEP)
                step_reg = data[PHASE_W-1:0];
            else if (idx == REG_ACTIVE_CHANNELS)
                chans_reg = data[CHAN_W-1:0];
        endfunction

        // Exact weighted sum, then truncation toward zero by signed division.
        function sample_t interpolate(sample_t a, sample_t b, logic [31:0] frac);
            longint weight;
            longint num;
            longint quo;
            weight = longint'({32'd0, frac});
            num    = longint'(a) * FRAC_SCALE + (longint'(b) - longint'(a)) * weight;
            quo    = num / FRAC_SCALE;
            return quo[SAMPLE_W-1:0];
        endfunction

        function void take_input_frame(logic st, sample_t s0, sample_t s1, sample_t s2,
                                       sample_t s3);
            sample_t    cur [SAMPLE_FIELDS];
            sample_t    val [SAMPLE_FIELDS];
            phase_t     stp;
            int         lanes;
            int         count;
            out_frame_t f;
            cur[0] = s0;
            cur[1] = s1;
            cur[2] = s2;
            cur[3] = s3;
            if (st || !primed)
            begin
                prev   = cur;
                phase  = '0;
                primed = 1'b1;
                return;
            end
            stp = (step_reg < STEP_MIN) ? STEP_MIN : (step_reg > STEP_MAX) ? STEP_MAX : step_reg;
            lanes = (chans_reg == 0) ? 1 : (chans_reg > SAMPLE_FIELDS) ? SAMPLE_FIELDS
                                                                      : int'(chans_reg);
            count = 0;
            while (phase < ONE_PHASE && count < RESULT_CAP)
            begin
                for (int c = 0; c < SAMPLE_FIELDS; c++)
                    val[c] = (c < lanes) ? interpolate(prev[c], cur[c], phase[31:0]) : '0;
                phase = phase + stp;
                count++;
                f.ch0  = val[0];
                f.ch1  = val[1];
                f.ch2  = val[2];
                f.ch3  = val[3];
                f.last = !(phase < ONE_PHASE && count < RESULT_CAP);
                pending_frames = {pending_frames, f};
            end
            phase = (phase >= ONE_PHASE) ? phase - ONE_PHASE : '0;
            prev  = cur;
        endfunction

        task check_output_frame(sample_t o0, sample_t o1, sample_t o2, sample_t o3,
                                logic lst);
            out_frame_t e;
            if (pending_frames.size() == 0)
            begin
                report($sformatf("unexpected word %0d %0d %0d %0d last %0b",
                                 o0, o1, o2, o3, lst));
                return;
            end
            e = pending_frames.pop_front();
            if (o0 !== e.ch0 || o1 !== e.ch1 || o2 !== e.ch2 || o3 !== e.ch3
                || lst !== e.last)
                report($sformatf("got %0d %0d %0d %0d last %0b, expected %0d %0d %0d %0d last %0b",
                                 o0, o1, o2, o3, lst, $signed(e.ch0), $signed(e.ch1),
                                 $signed(e.ch2), $signed(e.ch3), e.last));
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  start_req;
    sample_t               sample_0;
    sample_t               sample_1;
    sample_t               sample_2;
    sample_t               sample_3;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    sample_t               out_0;
    sample_t               out_1;
    sample_t               out_2;
    sample_t               out_3;
    logic                  last;

    bit quiet     = 1'b0;
    bit hold_long = 1'b0;

    frame_scoreboard sb = new();

    phase_accumulator_linear_resampler u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .start_req (start_req),
        .sample_0  (sample_0),
        .sample_1  (sample_1),
        .sample_2  (sample_2),
        .sample_3  (sample_3),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_0     (out_0),
        .out_1     (out_1),
        .out_2     (out_2),
        .out_3     (out_3),
        .last      (last)
    );

    always #HALF_PERIOD clk = ~clk;

    initial
    begin
        #(25_000_000);
        $display("FAILED: results differ");
        $finish;
    end

    // Receiver: random stall bursts, calm stretches, and one long hold-off on request.
    initial
    begin : output_side
        forever
        begin
            if (hold_long)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_long = 1'b0;
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else if (quiet || $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_output_frame(out_0, out_1, out_2, out_3, last);
    end

    function automatic sample_t rand_sample();
        case ($urandom_range(0, 11))
            0:       return S_MIN;
            1:       return S_MAX;
            2:       return '0;
            3:       return -16'sd1;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.apply_register(idx, data);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Offers one word and holds it until the block takes it.
    task automatic send_word(input logic st, input sample_t a, input sample_t b,
                             input sample_t c, input sample_t d);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        start_req <= st;
        sample_0  <= a;
        sample_1  <= b;
        sample_2  <= c;
        sample_3  <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.take_input_frame(st, a, b, c, d);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_frames.size() != 0);
    endtask

    // A word that yields no frame may still be in flight once the queue is empty.
    task automatic quiesce();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int                p;
        int                n;
        int                mode;
        int                random_sent;
        logic [4:0]        hi;
        phase_t            stp;
        logic [CHAN_W-1:0] nch;
        logic              st;

        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        start_req = 1'b0;
        sample_0  = '0;
        sample_1  = '0;
        sample_2  = '0;
        sample_3  = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset settings. The first word has no predecessor and so acts as a start.
        send_word(1'b0, S_MAX, S_MIN, 16'sd1234, -16'sd1);
        send_word(1'b0, S_MIN, S_MAX, '0, '0);
        send_word(1'b1, 16'sd5, 16'sd6, 16'sd7, 16'sd8);
        send_word(1'b0, -16'sd1, '0, S_MAX, S_MIN);
        quiesce();

        // Fractional step, all four lanes, full-scale swings.
        write_reg(REG_PHASE_STEP, CFG_DATA_W'(37'h00_6000_0000));
        write_reg(REG_ACTIVE_CHANNELS, CFG_DATA_W'(3'd4));
        send_word(1'b1, S_MIN, S_MAX, S_MIN, S_MAX);
        send_word(1'b0, S_MAX, S_MIN, '0, -16'sd1);
        send_word(1'b0, '0, '0, '0, '0);
        send_word(1'b0, -16'sd1, 16'sd1, S_MIN, S_MAX);
        quiesce();

        // Step below the floor and a zero channel count: 64 frames, one lane.
        write_reg(REG_PHASE_STEP, '0);
        write_reg(REG_ACTIVE_CHANNELS, '0);
        send_word(1'b1, S_MIN, 16'sd100, 16'sd200, 16'sd300);
        send_word(1'b0, S_MAX, -16'sd100, -16'sd200, -16'sd300);
        send_word(1'b0, S_MIN, S_MAX, S_MIN, S_MAX);
        quiesce();

        // Step above the ceiling and too many channels; the unused lanes stored
        // above must now come out.
        write_reg(REG_PHASE_STEP, CFG_DATA_W'(37'h1F_FFFF_FFFF));
        write_reg(REG_ACTIVE_CHANNELS, CFG_DATA_W'(3'd7));
        for (int i = 0; i < 6; i++)
            send_word(1'b0, rand_sample(), rand_sample(), rand_sample(), rand_sample());
        quiesce();
        write_reg(REG_SPARE, CFG_DATA_W'(37'h15_A5A5_5A5A));

        p           = 0;
        random_sent = 0;
        while (random_sent < RANDOM_WORDS)
        begin
            quiet = (random_sent >= QUIET_FROM);
            mode  = $urandom_range(0, 9);
            if (p == 1)
                stp = phase_t'(32'h4000_0000 + ($urandom() & 32'h3FFF_FFFF));
            else if (mode == 0)
                stp = phase_t'($urandom_range(0, 32'h0800_0000));
            else if (mode == 1)
            begin
                hi  = 5'($urandom_range(16, 31));
                stp = {hi, 32'($urandom())};
            end
            else
                stp = {3'b000, 2'($urandom_range(0, 3)), 32'($urandom())};
            nch = 3'($urandom_range(0, 7));
            write_reg(REG_PHASE_STEP, CFG_DATA_W'(stp));
            write_reg(REG_ACTIVE_CHANNELS, CFG_DATA_W'(nch));

            // Very small steps give up to 64 frames a word, so keep those runs short.
            n = (p != 1 && mode == 0) ? 8 : $urandom_range(30, 55);
            if (p == 1)
                hold_long = 1'b1;
            for (int i = 0; i < n; i++)
            begin
                if (i == 0)
                    st = ($urandom_range(0, 3) != 0);
                else
                    st = ($urandom_range(0, 24) == 0);
                send_word(st, rand_sample(), rand_sample(), rand_sample(), rand_sample());
                if (p == 2 && i == n / 2)
                    wait_drained();
            end
            random_sent += n;
            quiesce();
            p++;
        end

        if (sb.pending_frames.size() != 0)
            sb.report($sformatf("%0d expected words never arrived", sb.pending_frames.size()));
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: filelist.f
hdl/rsmp_pkg.sv
hdl/rsmp_lerp.sv
hdl/phase_accumulator_linear_resampler.sv
hdl/rsmp_checker.sv
verif/tb_phase_accumulator_linear_resampler.sv
